### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is low.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert that a condition never holds on a rising clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `ASSERT_AT(lbl, clk, rstn, !(expr), msg)

`endif

### rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Types, constants and helpers of the pending request tag table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned SLOTS    = 63;
  localparam int unsigned HANDLE_W = 6;
  localparam int unsigned NPOS     = SLOTS + 1;
  localparam int unsigned GRP      = 8;
  localparam int unsigned NGRP     = NPOS / GRP;
  localparam int unsigned GRP_W    = $clog2(GRP);
  localparam int unsigned NGRP_W   = $clog2(NGRP);

  typedef logic [NPOS-1:0] pos_vec_t;

  typedef enum logic [2:0] {
    MODE_ALLOC    = 3'd0,
    MODE_SET_CHAN = 3'd1,
    MODE_VALIDATE = 3'd2,
    MODE_LOOKUP   = 3'd3,
    MODE_REMOVE   = 3'd4
  } ptt_mode_e;

  typedef struct packed {
    logic [2:0]          mode;
    logic [HANDLE_W-1:0] handle;
    logic [7:0]          req_type;
    logic [7:0]          resp_type;
    logic                has_app_context;
    logic [31:0]         app_context;
    logic [7:0]          channel;
  } ptt_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic                ok;
    logic [7:0]          out_req_type;
    logic [7:0]          out_resp_type;
    logic                out_has_app_context;
    logic [31:0]         out_app_context;
    logic [7:0]          out_channel;
  } ptt_out_t;

  // One stored entry, less its channel
  typedef struct packed {
    logic [7:0]  req_type;
    logic [7:0]  resp_type;
    logic        has_app_context;
    logic [31:0] app_context;
  } ptt_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_item;
    logic scan;
    logic commit_alloc;
    logic write_chan;
    logic clear_entry;
    logic eval_lookup;
    logic eval_validate;
    logic load_out;
  } ptt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } ptt_status_t;

  // Lowest set bit of a position vector: {hit, index}, two-level search
  function automatic logic [HANDLE_W:0] find_first(pos_vec_t v);
    logic [NGRP-1:0]  grp_any;
    logic [GRP_W-1:0] grp_idx [NGRP];
    logic [NGRP_W-1:0] sel;
    int g;
    int b;
    sel = '0;
    for (g = 0; g < NGRP; g++) begin
      grp_any[g] = |v[g*GRP +: GRP];
      grp_idx[g] = '0;
      for (b = GRP - 1; b >= 0; b--) begin
        if (v[g*GRP + b]) begin
          grp_idx[g] = GRP_W'(b);
        end
      end
    end
    for (g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        sel = NGRP_W'(g);
      end
    end
    return {|grp_any, sel, grp_idx[sel]};
  endfunction

endpackage

### rtl/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: steps one transaction through scan and commit, act, or read and evaluate, then output.
// ----------------------------------------------------------------------------
module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [2:0]  in_mode_i,
  output logic        in_ready_o,
  input  ptt_status_t status_i,
  output ptt_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_ACT,
    S_READ,
    S_EVAL,
    S_DONE
  } state_e;

  state_e     state_q;
  logic [2:0] mode_q;
  logic       in_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= '0;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q     <= in_mode_i;
            in_ready_q <= 1'b0;
            case (in_mode_i)
              MODE_ALLOC:    state_q <= S_SCAN;
              MODE_SET_CHAN: state_q <= S_ACT;
              MODE_REMOVE:   state_q <= S_ACT;
              MODE_VALIDATE: state_q <= S_READ;
              MODE_LOOKUP:   state_q <= S_READ;
              default:       state_q <= S_DONE;
            endcase
          end
        end
        S_SCAN:  state_q <= S_PICK;
        S_PICK:  state_q <= S_DONE;
        S_ACT:   state_q <= S_DONE;
        S_READ:  state_q <= S_EVAL;
        S_EVAL:  state_q <= S_DONE;
        S_DONE: begin
          if (status_i.out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;

  always_comb begin
    cmd_o               = '0;
    cmd_o.take_item     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan          = (state_q == S_SCAN);
    cmd_o.commit_alloc  = (state_q == S_PICK);
    cmd_o.write_chan    = (state_q == S_ACT) && (mode_q == MODE_SET_CHAN);
    cmd_o.clear_entry   = (state_q == S_ACT) && (mode_q == MODE_REMOVE);
    cmd_o.eval_lookup   = (state_q == S_EVAL) && (mode_q == MODE_LOOKUP);
    cmd_o.eval_validate = (state_q == S_EVAL) && (mode_q == MODE_VALIDATE);
    cmd_o.load_out      = (state_q == S_DONE) && status_i.out_free;
  end

endmodule

### rtl/ptt_dpath.sv
// ----------------------------------------------------------------------------
// ptt_dpath
// Entry storage, free vector, next-fit search and output register.
// ----------------------------------------------------------------------------
module ptt_dpath
  import ptt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ptt_in_t     in_data_i,
  input  ptt_cmd_t    cmd_i,
  output ptt_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ptt_out_t    out_data_o
);

  localparam int unsigned ENTRY_W = $bits(ptt_entry_t);

  ptt_in_t             item_q;
  logic [HANDLE_W-1:0] cursor_q;
  pos_vec_t            busy_q;
  pos_vec_t            main_vld_q;
  pos_vec_t            chan_vld_q;
  pos_vec_t            hi_q;
  pos_vec_t            lo_q;
  ptt_out_t            res_q;
  ptt_out_t            out_q;
  logic                out_valid_q;

  pos_vec_t            free_vec;
  pos_vec_t            above;
  pos_vec_t            below;
  logic [HANDLE_W:0]   hi_ff;
  logic [HANDLE_W:0]   lo_ff;
  logic                pick_hit;
  logic [HANDLE_W-1:0] pick_idx;
  logic                in_range;
  ptt_entry_t          wr_entry;
  ptt_entry_t          rd_entry_raw;
  ptt_entry_t          rd_entry;
  logic [7:0]          rd_chan_raw;
  logic [7:0]          rd_chan;

  // Free slots: response type zero; position zero is never given out
  always_comb begin
    free_vec    = ~busy_q;
    free_vec[0] = 1'b0;
    for (int j = 0; j < NPOS; j++) begin
      above[j] = HANDLE_W'(j) > cursor_q;
      below[j] = HANDLE_W'(j) < cursor_q;
    end
  end

  assign hi_ff    = find_first(hi_q);
  assign lo_ff    = find_first(lo_q);
  assign pick_hit = hi_ff[HANDLE_W] | lo_ff[HANDLE_W];
  assign pick_idx = hi_ff[HANDLE_W] ? hi_ff[HANDLE_W-1:0] : lo_ff[HANDLE_W-1:0];

  assign in_range = (item_q.handle != '0) && (item_q.handle <= HANDLE_W'(SLOTS));

  assign wr_entry = '{req_type:        item_q.req_type,
                      resp_type:       item_q.resp_type,
                      has_app_context: item_q.has_app_context,
                      app_context:     item_q.app_context};

  ptt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NPOS)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit_alloc && pick_hit),
    .waddr_i(pick_idx),
    .wdata_i(wr_entry),
    .raddr_i(item_q.handle),
    .rdata_o(rd_entry_raw)
  );

  ptt_ram #(
    .WIDTH(8),
    .DEPTH(NPOS)
  ) u_chan_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write_chan && in_range),
    .waddr_i(item_q.handle),
    .wdata_i(item_q.channel),
    .raddr_i(item_q.handle),
    .rdata_o(rd_chan_raw)
  );

  // Entries never written since reset or removal read as zero
  assign rd_entry = main_vld_q[item_q.handle] ? rd_entry_raw : '0;
  assign rd_chan  = chan_vld_q[item_q.handle] ? rd_chan_raw : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q   <= '0;
      busy_q     <= '0;
      main_vld_q <= '0;
      chan_vld_q <= '0;
    end else begin
      if (cmd_i.commit_alloc && pick_hit) begin
        cursor_q             <= pick_idx;
        main_vld_q[pick_idx] <= 1'b1;
        busy_q[pick_idx]     <= item_q.resp_type != '0;
      end
      if (cmd_i.write_chan && in_range) begin
        chan_vld_q[item_q.handle] <= 1'b1;
      end
      if (cmd_i.clear_entry && in_range) begin
        main_vld_q[item_q.handle] <= 1'b0;
        chan_vld_q[item_q.handle] <= 1'b0;
        busy_q[item_q.handle]     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      item_q <= in_data_i;
      res_q  <= '0;
    end
    if (cmd_i.scan) begin
      hi_q <= free_vec & above;
      lo_q <= free_vec & below;
    end
    if (cmd_i.commit_alloc) begin
      res_q.handle_out <= pick_hit ? pick_idx : '0;
    end
    if (cmd_i.eval_lookup && in_range) begin
      res_q.ok                  <= 1'b1;
      res_q.out_req_type        <= rd_entry.req_type;
      res_q.out_resp_type       <= rd_entry.resp_type;
      res_q.out_has_app_context <= rd_entry.has_app_context;
      res_q.out_app_context     <= rd_entry.app_context;
      res_q.out_channel         <= rd_chan;
    end
    if (cmd_i.eval_validate) begin
      res_q.ok <= in_range && (rd_entry.resp_type == item_q.resp_type)
                  && (rd_chan == item_q.channel);
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

### rtl/pending_request_tag_table.sv
// ----------------------------------------------------------------------------
// pending_request_tag_table
// Table of outstanding requests with next-fit handle allocation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o carries one command transaction
//   (allocate, set channel, validate, lookup, remove); output channel
//   out_valid_o / out_ready_i returns exactly one result transaction each.
//   The table works on one transaction at a time: in_ready_o drops after an
//   accept and rises again once the result has entered the output register.
//   Allocate steps through scan, pick and done; validate and lookup
//   through read, eval and done; set channel and remove through act and
//   done; unused modes straight to done. The result is visible on
//   out_valid_o at the cycle the block is ready again. Allocation cost is
//   set by the search: free vector masked around the cursor, then a
//   two-level priority encode; reads by the registered entry RAM port.
//   Reset: cursor at zero, every slot free, no channel bound, output empty.
//   No clearing pass is needed; per-slot valid bits mask stale RAM data.
//   Receiver stall: the output register holds its transaction, the next
//   command is still accepted and worked, and its result waits until the
//   output register frees.
// ----------------------------------------------------------------------------
module pending_request_tag_table
  import ptt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ptt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ptt_out_t out_data_o
);

  ptt_cmd_t    cmd;
  ptt_status_t status;

  // Sequencer: advance one transaction through its steps
  ptt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_mode_i (in_data_i.mode),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Datapath: hold entries, search free slots, hold the result
  ptt_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### rtl/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the pending request tag table, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptt_checker
  import ptt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input ptt_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input ptt_out_t out_data_o
);

  logic in_fire;
  logic field_set;

  assign in_fire   = in_valid_i && in_ready_o && (in_data_i.mode == in_data_i.mode);
  assign field_set = (out_data_o.out_req_type != '0) || (out_data_o.out_resp_type != '0)
                     || out_data_o.out_has_app_context || (out_data_o.out_app_context != '0)
                     || (out_data_o.out_channel != '0);

  // A stalled result holds
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  // One transaction in work at a time
  `ASSERT_AT(a_one_in_work, clk_i, rst_ni, in_fire |=> !in_ready_o, "ready stayed high after accept")
  // A handle is never returned together with ok
  `ASSERT_NEVER(a_handle_ok_excl, clk_i, rst_ni, out_valid_o && out_data_o.ok && (out_data_o.handle_out != '0), "handle and ok both set")
  // Entry fields only come with a successful lookup
  `ASSERT_AT(a_fields_need_ok, clk_i, rst_ni, out_valid_o && field_set |-> out_data_o.ok, "entry fields without ok")

endmodule

bind pending_request_tag_table ptt_checker u_ptt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
